// ===== sv/peak_bar_centroid_finder_defines.svh =====
// Assertion macros for the peak bar centroid finder.
// Expects signals clk and arst_n in the scope of use.
`ifndef PEAK_BAR_CENTROID_FINDER_DEFINES_SVH
`define PEAK_BAR_CENTROID_FINDER_DEFINES_SVH

// same-cycle implication, checked out of reset
`define PBCF_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, checked out of reset
`define PBCF_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== sv/pbcf_pkg.sv =====
// Package for the peak bar centroid finder: field widths, register indexes,
// reset values, sequencer state type. No dependencies.
`default_nettype none

package pbcf_pkg;

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_READ,
		ST_SCALE,
		ST_PREP,
		ST_DIV,
		ST_DONE
	} state_t;

	localparam int E_W         = 20;
	localparam int C_W         = 16;
	localparam int THR_W       = 20;
	localparam int PITCH_W     = 12;
	localparam int POS_W       = 15;
	localparam int IDX_OUT_W   = 5;
	localparam int LAYNUM_W    = 3;
	localparam int LOWCNT_W    = 4;
	localparam int TE_W        = 22;
	localparam int DIV_W       = TE_W + 1;
	localparam int IN_TDATA_W  = 40;
	localparam int OUT_TDATA_W = 48;
	localparam int CFG_IDX_W   = 1;
	localparam int CFG_W       = 20;

	localparam logic [CFG_IDX_W-1:0] REG_THRESHOLD = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_PITCH     = 1'b1;

	localparam logic [THR_W-1:0]    THR_RST    = 20'd500;
	localparam logic [PITCH_W-1:0]  PITCH_RST  = 12'd789;
	localparam logic [POS_W-1:0]    POS_MAX    = 15'h7fff;
	localparam logic [LOWCNT_W-1:0] LOWCNT_MAX = 4'hf;

	// neighbourhood read slots
	localparam logic [1:0] RD_LEFT  = 2'd0;
	localparam logic [1:0] RD_PEAK  = 2'd1;
	localparam logic [1:0] RD_RIGHT = 2'd2;
	localparam logic [1:0] RD_DRAIN = 2'd3;

endpackage

`default_nettype wire

// ===== sv/peak_bar_centroid_finder.sv =====
// Peak bar centroid finder: top level, sequencer and serial divider.
// Depends on pbcf_pkg, pbcf_ram and peak_bar_centroid_finder_defines.svh.
//
//   channel  dir  fields (lowest bit first)
//   s        in   tdata: bar_energy, bar_second_coord
//   m        out  tdata: centroid_position, peak_bar_index, peak_coord,
//                        layer_number, low_layer_count; tuser: layer_low;
//                        tlast: event_last
//   cfg      in   index 0 low_peak_threshold, index 1 bar_pitch
//
// Bars transfer one per cycle while a layer is loading. After the last bar of a
// layer the block is not ready while it does neighbour reads from the bar RAM,
// a scale multiply, a prep step and the restoring divider (one quotient bit per
// cycle; skipped for a zero energy sum or a clamped result), then hands over the
// result. Reset clears control and counters; the bar RAM needs none.
// A result waiting in the output register does not block loading of the next
// layer; only the hand-over cycle waits for it.
`default_nettype none
`include "peak_bar_centroid_finder_defines.svh"

module peak_bar_centroid_finder #(
	parameter int BARS_PER_LAYER   = 22,
	parameter int LAYERS_PER_EVENT = 8
) (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// bar_energy, bar_second_coord
	input  logic [pbcf_pkg::IN_TDATA_W-1:0]    s_tdata,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// centroid_position, peak_bar_index, peak_coord, layer_number,
	// low_layer_count
	output logic [pbcf_pkg::OUT_TDATA_W-1:0]   m_tdata,
	output logic                               m_tlast,
	// layer_low
	output logic                               m_tuser,
	input  logic                               cfg_wr_en,
	input  logic [pbcf_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [pbcf_pkg::CFG_W-1:0]         cfg_data
);

	import pbcf_pkg::*;

	localparam int IDX_W  = $clog2(BARS_PER_LAYER);
	localparam int LAY_W  = (LAYERS_PER_EVENT > 1) ? $clog2(LAYERS_PER_EVENT) : 1;
	localparam int PROD_W = E_W + IDX_W;
	localparam int TEB_W  = PROD_W + 2;
	localparam int SUM_W  = TEB_W + 2;
	localparam int NUM_W  = SUM_W + PITCH_W;
	localparam int CMP_W  = NUM_W - POS_W;
	localparam logic [IDX_W-1:0] BAR_LAST = IDX_W'(BARS_PER_LAYER - 1);
	localparam logic [LAY_W-1:0] LAY_LAST = LAY_W'(LAYERS_PER_EVENT - 1);
	localparam logic [3:0]       DIV_LAST = 4'(POS_W - 1);

	state_t state_q, state_d;

	logic [THR_W-1:0]    thr_q;
	logic [PITCH_W-1:0]  pitch_q;
	logic [IDX_W-1:0]    bar_q;
	logic [E_W-1:0]      peak_e_q;
	logic [IDX_W-1:0]    peak_idx_q;
	logic [LAY_W-1:0]    lay_q;
	logic [LOWCNT_W-1:0] low_q;
	logic [TE_W-1:0]     te_q;
	logic [TEB_W-1:0]    teb_q;
	logic [1:0]          rd_cnt_q;
	logic                rd_vld_s1;
	logic                rd_peak_s1;
	logic [IDX_W-1:0]    rd_idx_s1;
	logic [C_W-1:0]      coord_q;
	logic [NUM_W-1:0]    num_q;
	logic [DIV_W-1:0]    rem_q;
	logic [POS_W-1:0]    low_bits_q;
	logic [POS_W-1:0]    res_q;
	logic [3:0]          div_cnt_q;

	logic                m_tvalid_q;
	logic [POS_W-1:0]    out_pos_q;
	logic [IDX_W-1:0]    out_idx_q;
	logic [C_W-1:0]      out_coord_q;
	logic                out_low_q;
	logic [LAY_W-1:0]    out_lay_q;
	logic [LOWCNT_W-1:0] out_cnt_q;
	logic                out_last_q;

	logic                in_acc;
	logic [E_W-1:0]      in_e;
	logic [C_W-1:0]      in_c;
	logic                ram_we;
	logic [IDX_W-1:0]    ram_raddr;
	logic [E_W+C_W-1:0]  ram_rdata;
	logic [E_W-1:0]      rd_e;
	logic [C_W-1:0]      rd_c;
	logic [IDX_W:0]      rd_pos;
	logic                rd_in_range;
	logic [PROD_W-1:0]   prod;
	logic [SUM_W-1:0]    sum;
	logic [DIV_W-1:0]    d_val;
	logic [CMP_W-1:0]    num_hi;
	logic [DIV_W:0]      rem_sh;
	logic                fits;
	logic                out_fire;
	logic                low_now;
	logic [LOWCNT_W-1:0] low_next;
	logic                last_layer;
	logic [IDX_W+IDX_OUT_W-1:0]  idx_ext;
	logic [LAY_W+LAYNUM_W-1:0]   lay_ext;

	assign in_e   = s_tdata[E_W-1:0];
	assign in_c   = s_tdata[E_W+C_W-1:E_W];
	assign in_acc = s_tvalid && s_tready;
	assign rd_e   = ram_rdata[E_W-1:0];
	assign rd_c   = ram_rdata[E_W+C_W-1:E_W];

	pbcf_ram #(
		.WIDTH(E_W + C_W),
		.DEPTH(BARS_PER_LAYER)
	) u_bar_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(bar_q),
		.wdata({in_c, in_e}),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	// neighbour read address
	assign rd_pos = {1'b0, peak_idx_q} + (IDX_W+1)'(rd_cnt_q) - (IDX_W+1)'(1);
	always_comb begin
		case (rd_cnt_q)
			RD_LEFT:  rd_in_range = (peak_idx_q != '0);
			RD_PEAK:  rd_in_range = 1'b1;
			RD_RIGHT: rd_in_range = ({1'b0, peak_idx_q} + (IDX_W+1)'(1)) <
				(IDX_W+1)'(BARS_PER_LAYER);
			default:  rd_in_range = 1'b0;
		endcase
	end
	assign ram_raddr = rd_in_range ? rd_pos[IDX_W-1:0] : peak_idx_q;

	assign prod   = PROD_W'(rd_e) * PROD_W'(rd_idx_s1);
	assign sum    = SUM_W'({teb_q, 1'b0}) + SUM_W'(te_q);
	assign d_val  = {te_q, 1'b0};
	assign num_hi = num_q[NUM_W-1:POS_W];
	assign rem_sh = {rem_q, low_bits_q[POS_W-1]};
	assign fits   = rem_sh >= (DIV_W+1)'(d_val);

	assign low_now    = peak_e_q < thr_q;
	assign low_next   = (low_now && (low_q != LOWCNT_MAX)) ? low_q + 1'b1 : low_q;
	assign last_layer = (lay_q == LAY_LAST);

	// sequencer
	always_comb begin
		state_d  = state_q;
		s_tready = 1'b0;
		ram_we   = 1'b0;
		out_fire = 1'b0;
		case (state_q)
			ST_LOAD: begin
				s_tready = 1'b1;
				ram_we   = s_tvalid;
				if (s_tvalid && (bar_q == BAR_LAST)) begin
					state_d = ST_READ;
				end
			end
			ST_READ: begin
				if (rd_cnt_q == RD_DRAIN) begin
					state_d = ST_SCALE;
				end
			end
			ST_SCALE: state_d = ST_PREP;
			ST_PREP: begin
				if ((te_q == '0) || (num_hi >= CMP_W'(d_val))) begin
					state_d = ST_DONE;
				end else begin
					state_d = ST_DIV;
				end
			end
			ST_DIV: begin
				if (div_cnt_q == DIV_LAST) begin
					state_d = ST_DONE;
				end
			end
			ST_DONE: begin
				if (!m_tvalid_q || m_tready) begin
					out_fire = 1'b1;
					state_d  = ST_LOAD;
				end
			end
			default: state_d = ST_LOAD;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
		end else begin
			state_q <= state_d;
		end
	end

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= THR_RST;
			pitch_q <= PITCH_RST;
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_THRESHOLD: thr_q   <= cfg_data[THR_W-1:0];
				REG_PITCH:     pitch_q <= cfg_data[PITCH_W-1:0];
				default:       ;
			endcase
		end
	end

	// control: counters, peak tracking, read pipeline valid, output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bar_q      <= '0;
			peak_e_q   <= '0;
			peak_idx_q <= '0;
			lay_q      <= '0;
			low_q      <= '0;
			rd_cnt_q   <= RD_LEFT;
			rd_vld_s1  <= 1'b0;
			div_cnt_q  <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (in_acc) begin
				bar_q <= (bar_q == BAR_LAST) ? '0 : bar_q + 1'b1;
				if (in_e > peak_e_q) begin
					peak_e_q   <= in_e;
					peak_idx_q <= bar_q;
				end
			end
			rd_vld_s1 <= (state_q == ST_READ) && rd_in_range;
			rd_cnt_q  <= (state_q == ST_READ) ? rd_cnt_q + 1'b1 : RD_LEFT;
			div_cnt_q <= (state_q == ST_DIV) ? div_cnt_q + 1'b1 : '0;
			if (out_fire) begin
				m_tvalid_q <= 1'b1;
				peak_e_q   <= '0;
				peak_idx_q <= '0;
				if (last_layer) begin
					lay_q <= '0;
					low_q <= '0;
				end else begin
					lay_q <= lay_q + 1'b1;
					low_q <= low_next;
				end
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_acc && (bar_q == BAR_LAST)) begin
			te_q  <= '0;
			teb_q <= '0;
		end else if (rd_vld_s1) begin
			te_q  <= te_q + TE_W'(rd_e);
			teb_q <= teb_q + TEB_W'(prod);
		end
		rd_idx_s1  <= ram_raddr;
		rd_peak_s1 <= (state_q == ST_READ) && (rd_cnt_q == RD_PEAK);
		if (rd_peak_s1) begin
			coord_q <= rd_c;
		end
		if (state_q == ST_SCALE) begin
			num_q <= NUM_W'(sum) * NUM_W'(pitch_q);
		end
		if (state_q == ST_PREP) begin
			rem_q      <= DIV_W'(num_hi);
			low_bits_q <= num_q[POS_W-1:0];
			if (te_q == '0) begin
				res_q <= POS_W'(pitch_q >> 1);
			end else begin
				res_q <= POS_MAX;
			end
		end
		if (state_q == ST_DIV) begin
			rem_q      <= fits ? DIV_W'(rem_sh - (DIV_W+1)'(d_val)) : DIV_W'(rem_sh);
			low_bits_q <= {low_bits_q[POS_W-2:0], 1'b0};
			res_q      <= {res_q[POS_W-2:0], fits};
		end
		if (out_fire) begin
			out_pos_q   <= res_q;
			out_idx_q   <= peak_idx_q;
			out_coord_q <= coord_q;
			out_low_q   <= low_now;
			out_lay_q   <= lay_q;
			out_cnt_q   <= low_next;
			out_last_q  <= last_layer;
		end
	end

	assign idx_ext = {{IDX_OUT_W{1'b0}}, out_idx_q};
	assign lay_ext = {{LAYNUM_W{1'b0}}, out_lay_q};

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {5'b0, out_cnt_q, lay_ext[LAYNUM_W-1:0], out_coord_q,
		idx_ext[IDX_OUT_W-1:0], out_pos_q};
	assign m_tlast  = out_last_q;
	assign m_tuser  = out_low_q;

	`PBCF_ASSERT_NOW(a_div_rem_bound, state_q == ST_DIV, rem_q < d_val,
		"divider remainder not below divisor")
	`PBCF_ASSERT_NOW(a_rd_from_seq, rd_vld_s1, $past(state_q) == ST_READ,
		"neighbour read valid outside read phase")
	`PBCF_ASSERT_NOW(a_result_from_done, $rose(m_tvalid_q), $past(state_q) == ST_DONE,
		"result appeared without finishing a layer")
	`PBCF_ASSERT_NEXT(a_last_bar_locks, in_acc && (bar_q == BAR_LAST), !s_tready,
		"ready stayed high after the last bar of a layer")

endmodule

`default_nettype wire

// ===== sv/pbcf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module pbcf_ram #(
	parameter int WIDTH = 36,
	parameter int DEPTH = 22,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// ===== tb/pbcf_checker.sv =====
// Checker for the peak bar centroid finder: watches the bar, result and register
// channels, predicts each layer result and compares it field by field.
// Depends on pbcf_pkg.
module pbcf_checker #(
	parameter int BARS_PER_LAYER   = 22,
	parameter int LAYERS_PER_EVENT = 8
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             s_tvalid,
	input  logic                             s_tready,
	// bar_energy, bar_second_coord
	input  logic [pbcf_pkg::IN_TDATA_W-1:0]  s_tdata,
	input  logic                             m_tvalid,
	input  logic                             m_tready,
	// centroid_position, peak_bar_index, peak_coord, layer_number, low_layer_count
	input  logic [pbcf_pkg::OUT_TDATA_W-1:0] m_tdata,
	input  logic                             m_tlast,
	// layer_low
	input  logic                             m_tuser,
	input  logic                             cfg_wr_en,
	input  logic [pbcf_pkg::CFG_IDX_W-1:0]   cfg_index,
	input  logic [pbcf_pkg::CFG_W-1:0]       cfg_data,
	output int unsigned                      fail_count,
	output int unsigned                      pending
);
	timeunit 1ns;
	timeprecision 1ps;

	import pbcf_pkg::*;

	localparam int IDX_LSB    = POS_W;
	localparam int COORD_LSB  = IDX_LSB + IDX_OUT_W;
	localparam int LAYNUM_LSB = COORD_LSB + C_W;
	localparam int LOWCNT_LSB = LAYNUM_LSB + LAYNUM_W;

	typedef struct {
		logic [POS_W-1:0]        centre;
		logic [IDX_OUT_W-1:0]    peak_idx;
		logic signed [C_W-1:0]   peak_coord;
		logic                    low;
		logic [LAYNUM_W-1:0]     layer_no;
		logic [LOWCNT_W-1:0]     low_cnt;
		logic                    evt_last;
	} layer_result_t;

	logic [THR_W-1:0]      thr_reg;
	logic [PITCH_W-1:0]    pitch_reg;
	logic [E_W-1:0]        bar_energy_mem [BARS_PER_LAYER];
	logic [C_W-1:0]        bar_coord_mem [BARS_PER_LAYER];
	logic [E_W-1:0]        run_peak_energy;
	logic [IDX_OUT_W-1:0]  run_peak_idx;
	logic [IDX_OUT_W-1:0]  bar_pos;
	int unsigned           layer_pos;
	logic [LOWCNT_W-1:0]   low_layers;
	int unsigned           n_checked;
	layer_result_t         layer_results_q [$];

	task automatic flag_error(input string msg);
		$display("[%0t] ERROR %s", $time, msg);
		fail_count++;
	endtask

	// centre of gravity over the peak bar and its neighbours, plus half a bar, times pitch
	function automatic logic [POS_W-1:0] weighted_centre();
		longint unsigned p, ev, te, teb, q;
		p = run_peak_idx;
		ev = bar_energy_mem[p];
		te = ev;
		teb = ev * p;
		if (p != 0) begin
			ev = bar_energy_mem[p - 1];
			te += ev;
			teb += ev * (p - 1);
		end
		if (p + 1 < BARS_PER_LAYER) begin
			ev = bar_energy_mem[p + 1];
			te += ev;
			teb += ev * (p + 1);
		end
		if (te == 0)
			return POS_W'(pitch_reg >> 1);
		q = (2 * teb + te) * longint'(pitch_reg) / (2 * te);
		if (q > POS_MAX)
			q = POS_MAX;
		return q[POS_W-1:0];
	endfunction

	task automatic take_bar(input logic [E_W-1:0] e, input logic [C_W-1:0] c);
		layer_result_t r;
		logic [IDX_OUT_W-1:0] b;
		b = bar_pos;
		bar_energy_mem[b] = e;
		bar_coord_mem[b] = c;
		if (e > run_peak_energy) begin
			run_peak_energy = e;
			run_peak_idx = b;
		end
		if (b + 1 < BARS_PER_LAYER) begin
			bar_pos = b + 1'b1;
		end else begin
			r.low = run_peak_energy < thr_reg;
			if (r.low && low_layers < LOWCNT_MAX)
				low_layers++;
			r.evt_last = layer_pos + 1 >= LAYERS_PER_EVENT;
			r.centre = weighted_centre();
			r.peak_idx = run_peak_idx;
			r.peak_coord = bar_coord_mem[run_peak_idx];
			r.layer_no = layer_pos[LAYNUM_W-1:0];
			r.low_cnt = low_layers;
			layer_results_q.insert(layer_results_q.size(), r);
			bar_pos = '0;
			run_peak_energy = '0;
			run_peak_idx = '0;
			if (r.evt_last) begin
				layer_pos = 0;
				low_layers = '0;
			end else begin
				layer_pos++;
			end
		end
	endtask

	task automatic cmp_field(input string name, input longint unsigned got,
			input longint unsigned want);
		if (got != want)
			flag_error($sformatf("layer result %0d: %s got 0x%0h, want 0x%0h",
				n_checked, name, got, want));
	endtask

	task automatic check_result();
		layer_result_t w;
		if (layer_results_q.size() == 0) begin
			flag_error($sformatf("result transfer with nothing pending, tdata 0x%0h", m_tdata));
		end else begin
			w = layer_results_q.pop_front();
			cmp_field("centroid_position", m_tdata[POS_W-1:0], w.centre);
			cmp_field("peak_bar_index", m_tdata[IDX_LSB +: IDX_OUT_W], w.peak_idx);
			cmp_field("peak_coord", m_tdata[COORD_LSB +: C_W], w.peak_coord[C_W-1:0]);
			cmp_field("layer_number", m_tdata[LAYNUM_LSB +: LAYNUM_W], w.layer_no);
			cmp_field("low_layer_count", m_tdata[LOWCNT_LSB +: LOWCNT_W], w.low_cnt);
			cmp_field("layer_low", m_tuser, w.low);
			cmp_field("event_last", m_tlast, w.evt_last);
			n_checked++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_reg = THR_RST;
			pitch_reg = PITCH_RST;
			run_peak_energy = '0;
			run_peak_idx = '0;
			bar_pos = '0;
			layer_pos = 0;
			low_layers = '0;
			n_checked = 0;
			fail_count = 0;
			layer_results_q.delete();
		end else begin
			if (cfg_wr_en) begin
				case (cfg_index)
					REG_THRESHOLD: thr_reg = cfg_data[THR_W-1:0];
					REG_PITCH:     pitch_reg = cfg_data[PITCH_W-1:0];
					default: ;
				endcase
			end
			if (s_tvalid && s_tready)
				take_bar(s_tdata[E_W-1:0], s_tdata[E_W +: C_W]);
			if (m_tvalid && m_tready)
				check_result();
		end
		pending = layer_results_q.size();
	end

endmodule

// ===== tb/tb_peak_bar_centroid_finder.sv =====
// Testbench top for the peak bar centroid finder: clock, reset, bar stimulus in
// bursts, output back-pressure, register phases and the verdict.
// Depends on pbcf_pkg, peak_bar_centroid_finder and pbcf_checker.
module tb_peak_bar_centroid_finder;
	timeunit 1ns;
	timeprecision 1ps;
	import pbcf_pkg::*;

	localparam int BARS_PER_LAYER   = 22;
	localparam int LAYERS_PER_EVENT = 8;
	localparam int SETTLE_CYCLES    = 40;
	localparam int CYCLE_LIMIT      = 400000;
	localparam int RANDOM_LAYERS    = 55;
	localparam logic [E_W-1:0] E_MAX = '1;

	typedef enum int {
		LY_ZERO, LY_FULL, LY_NEAR, LY_SMALL, LY_EDGE_LO, LY_EDGE_HI, LY_TIE, LY_SPARSE
	} layer_kind_t;

	typedef enum int {RX_OPEN, RX_COIN, RX_LONG} rx_mode_t;

	logic                   clk = 1'b0;
	logic                   arst_n;
	logic                   s_tvalid;
	logic                   s_tready;
	logic [IN_TDATA_W-1:0]  s_tdata;
	logic                   m_tvalid;
	logic                   m_tready = 1'b0;
	logic [OUT_TDATA_W-1:0] m_tdata;
	logic                   m_tlast;
	logic                   m_tuser;
	logic                   cfg_wr_en;
	logic [CFG_IDX_W-1:0]   cfg_index;
	logic [CFG_W-1:0]       cfg_data;
	int unsigned            fail_count;
	int unsigned            pending;

	rx_mode_t               rx_mode = RX_OPEN;
	int unsigned            stall_left = 0;
	int unsigned            burst_left = 0;
	int unsigned            cycles = 0;
	logic [THR_W-1:0]       cur_thr = THR_RST;
	int unsigned            layers_rand = 0;

	always #5 clk = ~clk;

	peak_bar_centroid_finder #(
		.BARS_PER_LAYER  (BARS_PER_LAYER),
		.LAYERS_PER_EVENT(LAYERS_PER_EVENT)
	) u_top (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tlast  (m_tlast),
		.m_tuser  (m_tuser),
		.cfg_wr_en(cfg_wr_en),
		.cfg_index(cfg_index),
		.cfg_data (cfg_data)
	);

	pbcf_checker #(
		.BARS_PER_LAYER  (BARS_PER_LAYER),
		.LAYERS_PER_EVENT(LAYERS_PER_EVENT)
	) u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.m_tuser   (m_tuser),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fail_count(fail_count),
		.pending   (pending)
	);

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Mismatches found");
			$finish;
		end
	end

	// result side back-pressure
	always @(negedge clk) begin
		if (stall_left != 0) begin
			m_tready <= 1'b0;
			stall_left <= stall_left - 1;
		end else begin
			case (rx_mode)
				RX_OPEN: m_tready <= 1'b1;
				RX_COIN: m_tready <= 1'($urandom_range(0, 1));
				default: begin
					if ($urandom_range(0, 7) == 0) begin
						stall_left <= $urandom_range(1, 40);
						m_tready <= 1'b0;
					end else begin
						m_tready <= 1'b1;
					end
				end
			endcase
		end
	end

	// one bar transfer; called and returns at a falling edge
	task automatic send_bar(input logic [E_W-1:0] e, input logic [C_W-1:0] c);
		if (burst_left == 0) begin
			s_tvalid = 1'b0;
			if ($urandom_range(0, 2) != 0)
				repeat ($urandom_range(1, 10)) @(negedge clk);
			burst_left = $urandom_range(1, 40);
		end
		s_tvalid = 1'b1;
		s_tdata = {{(IN_TDATA_W - E_W - C_W){1'b0}}, c, e};
		do @(posedge clk); while (!s_tready);
		@(negedge clk);
		burst_left--;
	endtask

	task automatic send_layer(input layer_kind_t kind);
		logic [E_W-1:0] e [BARS_PER_LAYER];
		logic [C_W-1:0] c [BARS_PER_LAYER];
		int unsigned hot, other, near_hi;
		logic [E_W-1:0] v;
		near_hi = int'(cur_thr) + 1;
		if (near_hi > E_MAX)
			near_hi = E_MAX;
		for (int i = 0; i < BARS_PER_LAYER; i++) begin
			case ($urandom_range(0, 15))
				0:       c[i] = 16'h8000;
				1:       c[i] = 16'h7fff;
				default: c[i] = C_W'($urandom);
			endcase
			case (kind)
				LY_ZERO, LY_SPARSE: e[i] = '0;
				LY_FULL:            e[i] = E_W'($urandom);
				LY_NEAR:            e[i] = E_W'($urandom_range(0, near_hi));
				LY_SMALL:           e[i] = E_W'($urandom_range(0, 7));
				default:            e[i] = E_W'($urandom_range(0, 1000));
			endcase
		end
		v = $urandom_range(0, 1) ? E_MAX : E_W'($urandom_range(1001, E_MAX - 1));
		hot = $urandom_range(0, BARS_PER_LAYER - 1);
		case (kind)
			LY_EDGE_LO: e[0] = v;
			LY_EDGE_HI: e[BARS_PER_LAYER-1] = v;
			LY_TIE: begin
				other = (hot + $urandom_range(1, BARS_PER_LAYER - 1)) % BARS_PER_LAYER;
				e[hot] = v;
				e[other] = v;
			end
			LY_SPARSE: begin
				e[hot] = E_W'($urandom);
				if (hot + 1 < BARS_PER_LAYER && $urandom_range(0, 1))
					e[hot + 1] = E_W'($urandom);
			end
			default: ;
		endcase
		for (int i = 0; i < BARS_PER_LAYER; i++)
			send_bar(e[i], c[i]);
	endtask

	task automatic wait_idle();
		s_tvalid = 1'b0;
		while (pending != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
		cfg_index = idx;
		cfg_data = val;
		cfg_wr_en = 1'b1;
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	task automatic set_regs(input logic [THR_W-1:0] thr, input logic [PITCH_W-1:0] pitch);
		wait_idle();
		write_reg(REG_THRESHOLD, CFG_W'(thr));
		write_reg(REG_PITCH, CFG_W'(pitch));
		cur_thr = thr;
		rx_mode = rx_mode_t'($urandom_range(0, 2));
	endtask

	initial begin
		logic [THR_W-1:0] thr;
		logic [PITCH_W-1:0] pitch;
		s_tvalid = 1'b0;
		s_tdata = '0;
		cfg_wr_en = 1'b0;
		cfg_index = REG_THRESHOLD;
		cfg_data = '0;
		arst_n = 1'b0;
		repeat (11) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		// reset settings: empty layer, peaks at both edges, tied peaks, lone hits
		send_layer(LY_ZERO);
		send_layer(LY_EDGE_LO);
		send_layer(LY_EDGE_HI);
		send_layer(LY_TIE);
		send_layer(LY_SPARSE);

		set_regs('0, '1);
		send_layer(LY_EDGE_HI);
		send_layer(LY_FULL);
		send_layer(LY_ZERO);

		set_regs('1, 12'd1);
		send_layer(LY_FULL);
		send_layer(LY_EDGE_LO);

		// zero pitch
		set_regs(THR_W'($urandom_range(0, 2000)), '0);
		send_layer(LY_NEAR);
		send_layer(LY_ZERO);

		while (layers_rand < RANDOM_LAYERS) begin
			case ($urandom_range(0, 3))
				0:       thr = THR_W'($urandom);
				1:       thr = THR_W'($urandom_range(0, 2000));
				2:       thr = THR_W'($urandom_range(0, 20));
				default: thr = THR_W'($urandom_range(2000, 100000));
			endcase
			case ($urandom_range(0, 5))
				0:       pitch = '1;
				1:       pitch = PITCH_W'($urandom_range(1, 15));
				2:       pitch = PITCH_RST;
				3:       pitch = ($urandom_range(0, 3) == 0) ? '0 : PITCH_W'($urandom_range(1, 4095));
				default: pitch = PITCH_W'($urandom_range(1, 4095));
			endcase
			set_regs(thr, pitch);
			repeat ($urandom_range(3, 10)) begin
				send_layer(layer_kind_t'($urandom_range(0, 7)));
				layers_rand++;
			end
		end

		wait_idle();
		if (fail_count == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule

// ===== peak_bar_centroid_finder.f =====
+incdir+sv
sv/pbcf_pkg.sv
sv/pbcf_ram.sv
sv/peak_bar_centroid_finder.sv
tb/pbcf_checker.sv
tb/tb_peak_bar_centroid_finder.sv
